/* hdl/rti_pkg.sv */
package rti_pkg;

  // default geometry: signed Q16.16 coordinates
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int NUM_VERTS = 3;
  localparam int EPS_W     = 31;
  localparam int BARY_W    = 31;
  localparam int BARY_FRAC = 30;

  // operand slice for split multipliers
  localparam int MUL_CHUNK = 17;

  localparam logic       ACT_LOAD  = 1'b0;
  localparam logic       ACT_RAY   = 1'b1;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

endpackage

/* hdl/rti_mul.sv */
module rti_mul
  import rti_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  // b is cut into MUL_CHUNK-bit slices; two register levels
  localparam int CW = MUL_CHUNK;
  localparam int NC = (BW + CW - 1) / CW;
  localparam int BX = NC * CW;
  localparam int PW = AW + BW;

  logic signed [BX-1:0]   bx;
  logic signed [AW+CW:0]  pp [NC];
  logic signed [PW-1:0]   acc;

  assign bx = BX'(b);

  for (genvar k = 0; k < NC; k++) begin : g_pp
    if (k == NC - 1) begin : g_top
      always_ff @(posedge clk) begin
        if (en) pp[k] <= a * $signed(bx[k*CW +: CW]);
      end
    end else begin : g_low
      always_ff @(posedge clk) begin
        if (en) pp[k] <= a * $signed({1'b0, bx[k*CW +: CW]});
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NC; k++) begin
      acc = acc + (PW'(pp[k]) <<< (k * CW));
    end
  end

  always_ff @(posedge clk) begin
    if (en) p <= acc;
  end

endmodule

/* hdl/rti_div.sv */
module rti_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q,
  output logic          ovf
);

  // restoring divider, one quotient bit per stage, QW+1 register levels
  logic [DW-1:0] rem   [QW+1];
  logic [DW-1:0] dd    [QW+1];
  logic [QW-1:0] lo    [QW+1];
  logic [QW-1:0] quo   [QW+1];
  logic          ovf_s [QW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= DW'(n >> QW);
      lo[0]    <= n[QW-1:0];
      quo[0]   <= '0;
      dd[0]    <= d;
      ovf_s[0] <= (n >> QW) >= NW'(d);
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        ge;

    assign r2   = {rem[g], lo[g][QW-1]};
    assign diff = r2 - (DW+1)'(dd[g]);
    assign ge   = r2 >= (DW+1)'(dd[g]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]   <= ge ? DW'(diff) : DW'(r2);
        lo[g+1]    <= lo[g] << 1;
        quo[g+1]   <= {quo[g][QW-2:0], ge};
        dd[g+1]    <= dd[g];
        ovf_s[g+1] <= ovf_s[g];
      end
    end
  end

  assign q   = quo[QW];
  assign ovf = ovf_s[QW];

endmodule

/* hdl/ray_triangle_intersect_unit.sv */
// Ray/triangle intersection (Moller-Trumbore), exact fixed point.
// Input channel (in_valid / in_stall): one transaction per cycle while
// in_stall is low. action selects a vertex load (vertex_slot 0..2,
// point_* = vertex; slot 3 is dropped) or a ray cast (point_* = origin,
// dir_* = direction). Loads give no result; each ray gives exactly one
// result transaction. Output channel (out_valid / out_stall): hit,
// dist_t (Q16.16, saturated), bary_u / bary_v (Q1.30). A miss returns
// all zeros. Rays cast before all three vertices are loaded miss.
// Config: cfg_wr_en / cfg_wr_data write det_epsilon; write only when idle.
// The pipeline depth is set mostly by the bit-per-stage dividers for t,
// u and v. Throughput: one ray per cycle unless the output is stalled.
// Stall: the whole pipeline freezes while a result sits in the output
// register and out_stall is high; in_stall follows immediately. Nothing
// is dropped or repeated.
// Reset (rst, sync): pipeline empty, vertex-loaded flags cleared,
// det_epsilon = 1. Vertex storage is not cleared.
module ray_triangle_intersect_unit
  import rti_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // config
  input  logic                         cfg_wr_en,
  input  logic [EPS_W-1:0]             cfg_wr_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [1:0]                   vertex_slot,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] dir_z,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] dist_t,
  output logic [BARY_W-1:0]            bary_u,
  output logic [BARY_W-1:0]            bary_v
);

  localparam int C   = COORD_BITS;
  localparam int E   = C + 1;           // edge / offset width
  localparam int PW  = 2 * E + 1;       // cross product width
  localparam int MW  = E + PW + 2;      // dot product width
  localparam int XW  = MW + 1;          // after sign fix
  localparam int DQW = (C > BARY_W) ? C : BARY_W;
  localparam int DEPTH = DQW + 10;      // stages ahead of the output reg

  // epsilon compare: mag * 2^32 vs eps * 2^(3F)
  localparam int F3   = 3 * FRAC_BITS;
  localparam int SH_M = (F3 >= 32) ? 0 : 32 - F3;
  localparam int SH_E = (F3 >= 32) ? F3 - 32 : 0;
  localparam int LW_A = XW + SH_M;
  localparam int LW_B = EPS_W + SH_E;
  localparam int LW   = ((LW_A > LW_B) ? LW_A : LW_B) + 1;

  // ---------------------------------------------------------------
  // handshake: everything advances unless a result is held
  // ---------------------------------------------------------------
  logic adv;
  logic in_acc;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign in_acc   = in_valid && adv;

  logic [EPS_W-1:0] det_epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= EPS_RESET;
    end else if (cfg_wr_en) begin
      det_epsilon <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------
  // triangle storage
  // ---------------------------------------------------------------
  logic signed [C-1:0] vtx [NUM_VERTS][3];
  logic [NUM_VERTS-1:0] loaded;
  logic                 load_acc;

  assign load_acc = in_acc && (action == ACT_LOAD) && (vertex_slot < 2'(NUM_VERTS));

  always_ff @(posedge clk) begin
    if (load_acc) begin
      vtx[vertex_slot][0] <= point_x;
      vtx[vertex_slot][1] <= point_y;
      vtx[vertex_slot][2] <= point_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (load_acc) begin
      loaded[vertex_slot] <= 1'b1;
    end
  end

  logic signed [C-1:0] pt [3];
  logic signed [C-1:0] dr [3];

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;
  assign dr[0] = dir_x;
  assign dr[1] = dir_y;
  assign dr[2] = dir_z;

  // ---------------------------------------------------------------
  // valid bits, one per stage, and triangle-complete flag up to stage 8
  // ---------------------------------------------------------------
  logic [DEPTH-1:0] vld;
  logic [7:0]       tri_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_acc && (action == ACT_RAY)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) tri_ok <= {tri_ok[6:0], &loaded};
  end

  // ---------------------------------------------------------------
  // stage 1: edges, origin offset, direction; carried to stage 4
  // ---------------------------------------------------------------
  logic signed [E-1:0] e1_p [4][3];
  logic signed [E-1:0] e2_p [4][3];
  logic signed [E-1:0] s_p  [4][3];
  logic signed [E-1:0] d_p  [4][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_p[0][i] <= E'(vtx[1][i]) - E'(vtx[0][i]);
        e2_p[0][i] <= E'(vtx[2][i]) - E'(vtx[0][i]);
        s_p[0][i]  <= E'(pt[i]) - E'(vtx[0][i]);
        d_p[0][i]  <= E'(dr[i]);
      end
      for (int st = 1; st < 4; st++) begin
        e1_p[st] <= e1_p[st-1];
        e2_p[st] <= e2_p[st-1];
        s_p[st]  <= s_p[st-1];
        d_p[st]  <= d_p[st-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // stages 2-4: p = d x e2, q = s x e1
  // ---------------------------------------------------------------
  logic signed [PW-1:0] p4 [3];
  logic signed [PW-1:0] q4 [3];

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [2*E-1:0] pa, pb, qa, qb;

    rti_mul #(.AW(E), .BW(E)) u_pa (
      .clk(clk), .en(adv), .a(d_p[0][J]), .b(e2_p[0][K]), .p(pa));
    rti_mul #(.AW(E), .BW(E)) u_pb (
      .clk(clk), .en(adv), .a(d_p[0][K]), .b(e2_p[0][J]), .p(pb));
    rti_mul #(.AW(E), .BW(E)) u_qa (
      .clk(clk), .en(adv), .a(s_p[0][J]), .b(e1_p[0][K]), .p(qa));
    rti_mul #(.AW(E), .BW(E)) u_qb (
      .clk(clk), .en(adv), .a(s_p[0][K]), .b(e1_p[0][J]), .p(qb));

    always_ff @(posedge clk) begin
      if (adv) begin
        p4[i] <= PW'(pa) - PW'(pb);
        q4[i] <= PW'(qa) - PW'(qb);
      end
    end
  end

  // ---------------------------------------------------------------
  // stages 5-7: det = e1.p, u = s.p, v = d.q, t = e2.q
  // ---------------------------------------------------------------
  logic signed [E+PW-1:0] t_mag [3];
  logic signed [E+PW-1:0] t_un  [3];
  logic signed [E+PW-1:0] t_vn  [3];
  logic signed [E+PW-1:0] t_tn  [3];

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.AW(E), .BW(PW)) u_mag (
      .clk(clk), .en(adv), .a(e1_p[3][i]), .b(p4[i]), .p(t_mag[i]));
    rti_mul #(.AW(E), .BW(PW)) u_un (
      .clk(clk), .en(adv), .a(s_p[3][i]), .b(p4[i]), .p(t_un[i]));
    rti_mul #(.AW(E), .BW(PW)) u_vn (
      .clk(clk), .en(adv), .a(d_p[3][i]), .b(q4[i]), .p(t_vn[i]));
    rti_mul #(.AW(E), .BW(PW)) u_tn (
      .clk(clk), .en(adv), .a(e2_p[3][i]), .b(q4[i]), .p(t_tn[i]));
  end

  logic signed [MW-1:0] mag7, un7, vn7, tn7;

  always_ff @(posedge clk) begin
    if (adv) begin
      mag7 <= MW'(t_mag[0]) + MW'(t_mag[1]) + MW'(t_mag[2]);
      un7  <= MW'(t_un[0])  + MW'(t_un[1])  + MW'(t_un[2]);
      vn7  <= MW'(t_vn[0])  + MW'(t_vn[1])  + MW'(t_vn[2]);
      tn7  <= MW'(t_tn[0])  + MW'(t_tn[1])  + MW'(t_tn[2]);
    end
  end

  // ---------------------------------------------------------------
  // stage 8: flip signs so the determinant is non-negative
  // ---------------------------------------------------------------
  logic signed [XW-1:0] mag8, un8, vn8, tn8;
  logic                 det_neg;

  assign det_neg = mag7[MW-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      mag8 <= det_neg ? -XW'(mag7) : XW'(mag7);
      un8  <= det_neg ? -XW'(un7)  : XW'(un7);
      vn8  <= det_neg ? -XW'(vn7)  : XW'(vn7);
      tn8  <= det_neg ? -XW'(tn7)  : XW'(tn7);
    end
  end

  // ---------------------------------------------------------------
  // stage 9: parallel / outside tests, |t|
  // ---------------------------------------------------------------
  logic [LW-1:0]        mag_sc, eps_sc;
  logic signed [XW:0]   uv_sum;
  logic                 ok_c;

  assign mag_sc = LW'($unsigned(mag8)) << SH_M;
  assign eps_sc = LW'(det_epsilon) << SH_E;
  assign uv_sum = (XW+1)'(un8) + (XW+1)'(vn8);

  assign ok_c = tri_ok[7]
             && (mag8 != '0)
             && !(mag_sc < eps_sc)
             && !un8[XW-1] && (un8 <= mag8)
             && !vn8[XW-1]
             && (uv_sum <= (XW+1)'(mag8));

  logic          ok9, tneg9;
  logic [XW-1:0] mag9, un9, vn9, tabs9;

  always_ff @(posedge clk) begin
    if (adv) begin
      ok9   <= ok_c;
      tneg9 <= tn8[XW-1];
      tabs9 <= tn8[XW-1] ? $unsigned(-tn8) : $unsigned(tn8);
      mag9  <= $unsigned(mag8);
      un9   <= $unsigned(un8);
      vn9   <= $unsigned(vn8);
    end
  end

  // ---------------------------------------------------------------
  // dividers: u, v in Q1.30, t in FRAC_BITS
  // ---------------------------------------------------------------
  logic [DQW-1:0] q_u, q_v, q_t;
  logic           t_ovf;

  rti_div #(.NW(XW + BARY_FRAC), .DW(XW), .QW(DQW)) u_div_u (
    .clk(clk), .en(adv), .n({un9, {BARY_FRAC{1'b0}}}), .d(mag9),
    .q(q_u), .ovf());

  rti_div #(.NW(XW + BARY_FRAC), .DW(XW), .QW(DQW)) u_div_v (
    .clk(clk), .en(adv), .n({vn9, {BARY_FRAC{1'b0}}}), .d(mag9),
    .q(q_v), .ovf());

  rti_div #(.NW(XW + FRAC_BITS), .DW(XW), .QW(DQW)) u_div_t (
    .clk(clk), .en(adv), .n({tabs9, {FRAC_BITS{1'b0}}}), .d(mag9),
    .q(q_t), .ovf(t_ovf));

  // hit flag and t sign ride alongside the dividers
  logic okd  [DQW+1];
  logic negd [DQW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      okd[0]  <= ok9;
      negd[0] <= tneg9;
      for (int st = 1; st <= DQW; st++) begin
        okd[st]  <= okd[st-1];
        negd[st] <= negd[st-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // t saturation and output register
  // ---------------------------------------------------------------
  logic [DQW-1:0]      t_cap, t_mag_sat;
  logic signed [C-1:0] t_val;
  logic                res_hit, res_neg;

  assign res_hit   = okd[DQW];
  assign res_neg   = negd[DQW];
  assign t_cap     = res_neg ? (DQW'(1) << (C - 1)) : ((DQW'(1) << (C - 1)) - DQW'(1));
  assign t_mag_sat = (t_ovf || (q_t > t_cap)) ? t_cap : q_t;
  assign t_val     = res_neg ? -$signed(C'(t_mag_sat)) : $signed(C'(t_mag_sat));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit    <= res_hit;
      dist_t <= res_hit ? t_val : '0;
      bary_u <= res_hit ? BARY_W'(q_u) : '0;
      bary_v <= res_hit ? BARY_W'(q_v) : '0;
    end
  end

endmodule
